>>> rtl/sequence_replay_window_check_unit_macros.svh
// Assertion macros for the replay window check unit.
// Used by the top level only; expects signals clock and reset in scope.
`ifndef SEQUENCE_REPLAY_WINDOW_CHECK_UNIT_MACROS_SVH
`define SEQUENCE_REPLAY_WINDOW_CHECK_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SRWC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SRWC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/srwc_pkg.sv
// Shared types and constants for the replay window check unit.
// No dependencies.
package srwc_pkg;

   localparam int SEQ_W           = 32;
   localparam int VERDICT_W       = 2;
   localparam int WINDOW_SIZE_DEF = 128;

   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_LOW  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_SEEN     = 2'd2;

   typedef struct packed {
      logic                 accepted;
      logic [VERDICT_W-1:0] verdict;
      logic [SEQ_W-1:0]     highest_after;
   } srwc_result_type;

endpackage

>>> rtl/srwc_in_stage.sv
// Input register for the replay window check unit.
// Depends on srwc_pkg.
module srwc_in_stage
   import srwc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SEQ_W-1:0] req_seq_number,
   input  logic             take,
   output logic             fire,
   output logic [SEQ_W-1:0] seq
);

   logic             vld_ff, vld_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic             load;

   assign fire      = vld_ff & take;
   assign req_stall = vld_ff & ~take;
   assign load      = req_valid & ~req_stall;
   assign seq       = seq_ff;

   always_comb begin
      vld_in = load | (vld_ff & ~fire);
      seq_in = load ? req_seq_number : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      seq_ff <= seq_in;
   end

endmodule

>>> rtl/srwc_window.sv
// Window state (highest number, seen-map) and the per-transaction decision.
// Depends on srwc_pkg.
module srwc_window
   import srwc_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF  // power of two
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [SEQ_W-1:0] seq,
   output srwc_result_type  result
);

   localparam int IDX_W = $clog2(WINDOW_SIZE);

   logic [SEQ_W-1:0]       hs_ff, hs_in;
   logic [WINDOW_SIZE-1:0] map_ff, map_in;

   logic                   above, big_jump, too_low, seen;
   logic [SEQ_W-1:0]       diff;
   logic [IDX_W-1:0]       step, slot, base;
   logic [WINDOW_SIZE-1:0] clr_mask, set_mask;
   logic [VERDICT_W-1:0]   verdict;

   assign slot = seq[IDX_W-1:0];
   assign base = hs_ff[IDX_W-1:0];
   assign diff = seq - hs_ff;
   assign step = diff[IDX_W-1:0];

   always_comb begin
      above    = seq > hs_ff;
      big_jump = {1'b0, seq} >= ({1'b0, hs_ff} + (SEQ_W+1)'(WINDOW_SIZE));
      too_low  = ({1'b0, seq} + (SEQ_W+1)'(WINDOW_SIZE)) <= {1'b0, hs_ff};
      seen     = map_ff[slot];
   end

   // slots of the skipped numbers and of the new highest sit 1..step past the old highest
   always_comb begin
      logic [IDX_W-1:0] off;
      clr_mask = '0;
      set_mask = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         off         = IDX_W'(i) - base;
         clr_mask[i] = (off != '0) && (off <= step);
      end
      set_mask[slot] = 1'b1;
   end

   always_comb begin
      hs_in  = hs_ff;
      map_in = map_ff;
      if (above) begin
         verdict = VERDICT_ACCEPTED;
         hs_in   = seq;
         map_in  = (big_jump ? '0 : (map_ff & ~clr_mask)) | set_mask;
      end else if (too_low) begin
         verdict = VERDICT_TOO_LOW;
      end else if (seen) begin
         verdict = VERDICT_SEEN;
      end else begin
         verdict = VERDICT_ACCEPTED;
         map_in  = map_ff | set_mask;
      end
   end

   always_comb begin
      result.accepted      = (verdict == VERDICT_ACCEPTED);
      result.verdict       = verdict;
      result.highest_after = hs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff  <= '0;
         map_ff <= '0;
      end else if (fire) begin
         hs_ff  <= hs_in;
         map_ff <= map_in;
      end
   end

endmodule

>>> rtl/srwc_out_stage.sv
// Result register for the replay window check unit.
// Depends on srwc_pkg.
module srwc_out_stage
   import srwc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  srwc_result_type      result,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [SEQ_W-1:0]     rsp_highest_after
);

   logic            vld_ff, vld_in;
   srwc_result_type res_ff, res_in;

   // free when empty or when the held transaction leaves this cycle
   assign take = ~vld_ff | ~rsp_stall;

   always_comb begin
      vld_in = fire | (vld_ff & rsp_stall);
      res_in = fire ? result : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid         = vld_ff;
   assign rsp_accepted      = res_ff.accepted;
   assign rsp_verdict       = res_ff.verdict;
   assign rsp_highest_after = res_ff.highest_after;

endmodule

>>> rtl/sequence_replay_window_check_unit.sv
// Sliding-window anti-replay check, one sequence number per transaction.
// req_* carries the sequence number in; rsp_* returns accepted, verdict
// (accepted / below window / already seen) and the highest number after it.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// A transaction taken into the input register moves on into the result
// register, the second register, where rsp_valid goes high with its result.
// Throughput: one transaction per cycle while rsp_stall is low. The limit
// is the window state update: a 33-bit compare plus the per-slot clear
// mask, settled combinationally between the input and result registers.
// Reset (synchronous) empties both registers, sets the highest number to zero
// and clears the seen-map.
// While rsp_stall holds, the result register keeps its transaction, one more
// transaction waits in the input register, and then req_stall rises.
// WINDOW_SIZE must be a power of two.
// Depends on srwc_pkg, srwc_in_stage, srwc_window, srwc_out_stage and the assertion macro header.
`include "sequence_replay_window_check_unit_macros.svh"

module sequence_replay_window_check_unit
   import srwc_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SEQ_W-1:0]     req_seq_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [VERDICT_W-1:0] rsp_verdict,
   output logic [SEQ_W-1:0]     rsp_highest_after
);

   logic            take, fire;
   logic [SEQ_W-1:0] seq;
   srwc_result_type result;

   srwc_in_stage u_in (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seq_number (req_seq_number),
      .take           (take),
      .fire           (fire),
      .seq            (seq)
   );

   srwc_window #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .seq    (seq),
      .result (result)
   );

   srwc_out_stage u_out (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .result            (result),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_verdict       (rsp_verdict),
      .rsp_highest_after (rsp_highest_after)
   );

   `SRWC_ASSERT_SAME(a_accept_not_above_top, fire && result.accepted, result.highest_after >= seq, "accepted number above highest")
   `SRWC_ASSERT_SAME(a_too_low_needs_room, fire && (result.verdict == VERDICT_TOO_LOW), result.highest_after >= SEQ_W'(WINDOW_SIZE), "too-low verdict with small highest")
   `SRWC_ASSERT_NEXT(a_result_loaded, fire, rsp_valid && (rsp_verdict == $past(result.verdict)), "result register missed a transaction")

endmodule
